// ----- src/gsa_pkg.sv -----
// gsa_pkg: shared widths, defaults and the queue item type for grouped_sum_accumulator.
// No dependencies.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int GROUPS_DEFAULT = 1024;
    localparam int GROUP_W        = 10;
    localparam int VALUE_W        = 64;
    localparam int COUNT_W        = 11;

    typedef struct packed {
        logic [GROUP_W-1:0]        group;
        logic signed [VALUE_W-1:0] value;
        logic                      in_range;
        logic                      apply;
    } gsa_item_t;

endpackage

// ----- src/gsa_front.sv -----
// gsa_front: input beat capture and row classification (range check, apply decision).
// Depends on gsa_pkg; feeds gsa_queue.
`timescale 1ns / 1ps

module gsa_front
    import gsa_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [GROUP_W-1:0]        group_index,
    input  logic signed [VALUE_W-1:0] row_value,
    input  logic                      row_selected,
    input  logic                      value_present,
    input  logic                      clearing,
    input  logic                      q_full,
    output logic                      push,
    output gsa_item_t                 push_item
);

    logic      item_valid_reg;
    logic      item_valid_next;
    gsa_item_t item_reg;
    gsa_item_t item_next;
    logic      accept;
    logic      in_range;

    assign in_stall        = clearing || (item_valid_reg && q_full);
    assign accept          = in_valid && !in_stall;
    assign push            = item_valid_reg && !q_full;
    assign push_item       = item_reg;
    assign item_valid_next = accept || (item_valid_reg && q_full);
    assign in_range        = (32'(group_index) < GROUPS);

    always_comb
    begin
        item_next = item_reg;
        if (accept)
        begin
            item_next.group    = group_index;
            item_next.value    = row_value;
            item_next.in_range = in_range;
            item_next.apply    = row_selected && value_present && in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ----- src/gsa_queue.sv -----
// gsa_queue: two-entry queue of classified rows between front and back.
// Depends on gsa_pkg.
`timescale 1ns / 1ps

module gsa_queue
    import gsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  gsa_item_t push_item,
    output logic      full,
    input  logic      pop,
    output gsa_item_t head,
    output logic      empty
);

    gsa_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

endmodule

// ----- src/gsa_back.sv -----
// gsa_back: accumulator memory with read-modify-write sequencer, null count, result register.
// Depends on gsa_pkg; takes rows from gsa_queue.
`timescale 1ns / 1ps

module gsa_back
    import gsa_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  gsa_item_t                 q_head,
    output logic                      pop,
    output logic                      clearing,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [GROUP_W-1:0]        group_out,
    output logic                      applied,
    output logic signed [VALUE_W-1:0] group_sum,
    output logic [COUNT_W-1:0]        null_groups_left
);

    localparam int DEPTH = (GROUPS < 2**GROUP_W) ? GROUPS : 2**GROUP_W;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GROUPS + 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC} state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [AW-1:0]             clr_cnt_reg;
    logic [AW-1:0]             clr_cnt_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    gsa_item_t                 cur_reg;
    gsa_item_t                 cur_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [GROUP_W-1:0]        group_out_reg;
    logic [GROUP_W-1:0]        group_out_next;
    logic                      applied_reg;
    logic                      applied_next;
    logic signed [VALUE_W-1:0] sum_reg;
    logic signed [VALUE_W-1:0] sum_next;
    logic [COUNT_W-1:0]        null_left_reg;
    logic [COUNT_W-1:0]        null_left_next;

    logic [VALUE_W:0]          mem [DEPTH];
    logic [VALUE_W:0]          rd_data_reg;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [VALUE_W:0]          wr_data;

    logic                      old_null;
    logic signed [VALUE_W-1:0] old_sum;
    logic signed [VALUE_W-1:0] sum_new;
    logic                      out_fire;
    logic                      out_free;

    assign old_null = rd_data_reg[VALUE_W];
    assign old_sum  = rd_data_reg[VALUE_W-1:0];
    assign sum_new  = cur_reg.apply ? old_sum + cur_reg.value : old_sum;
    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign clearing = (state_reg == S_CLEAR);

    assign out_valid        = out_valid_reg;
    assign group_out        = group_out_reg;
    assign applied          = applied_reg;
    assign group_sum        = sum_reg;
    assign null_groups_left = null_left_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        group_out_next = group_out_reg;
        applied_next   = applied_reg;
        sum_next       = sum_reg;
        null_left_next = null_left_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cur_reg.group[AW-1:0];
        wr_data        = {1'b0, sum_new};

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = {1'b1, {VALUE_W{1'b0}}};
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    cur_next   = q_head;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                if (out_free)
                begin
                    wr_en = cur_reg.apply;
                    if (cur_reg.apply && old_null && (count_reg != '0))
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    out_valid_next = 1'b1;
                    group_out_next = cur_reg.group;
                    applied_next   = cur_reg.apply;
                    sum_next       = cur_reg.in_range ? sum_new : '0;
                    null_left_next = COUNT_W'(count_next);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            count_reg     <= CW'(GROUPS);
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            group_out_reg <= '0;
            applied_reg   <= 1'b0;
            sum_reg       <= '0;
            null_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            count_reg     <= count_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            group_out_reg <= group_out_next;
            applied_reg   <= applied_next;
            sum_reg       <= sum_next;
            null_left_reg <= null_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[q_head.group[AW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(GROUPS))
        else $error("null group count above group total");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !out_valid_reg)
        else $error("result beat during clear pass");

    a_calc_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("update did not load result register");

    a_applied_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && applied_reg) |-> (32'(group_out_reg) < GROUPS))
        else $error("applied row outside group range");

endmodule

// ----- src/grouped_sum_accumulator.sv -----
// grouped_sum_accumulator: top level of the group-by sum update engine.
// Depends on gsa_pkg, gsa_front, gsa_queue, gsa_back.
//
//   channel | handshake             | beat fields
//   --------+-----------------------+-------------------------------------------------
//   in      | in_valid / in_stall   | group_index, row_value, row_selected, value_present
//   out     | out_valid / out_stall | group_out, applied, group_sum, null_groups_left
//
// Each row passes through the back sequencer states S_IDLE, to pop it and read the accumulator
// memory, and S_CALC, to update, write back and load the result register; a new row is popped
// only after S_CALC. The front takes a beat per cycle until the two-entry queue fills.
// After reset a clear pass writes every accumulator entry, min(GROUPS, 1024) of them
// (1024 by default), with in_stall high.
// out_stall holds the result register and then the sequencer; rows back up into in_stall.
`timescale 1ns / 1ps

module grouped_sum_accumulator
    import gsa_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [GROUP_W-1:0]        group_index,
    input  logic signed [VALUE_W-1:0] row_value,
    input  logic                      row_selected,
    input  logic                      value_present,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [GROUP_W-1:0]        group_out,
    output logic                      applied,
    output logic signed [VALUE_W-1:0] group_sum,
    output logic [COUNT_W-1:0]        null_groups_left
);

    logic      clearing;
    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    gsa_item_t push_item;
    gsa_item_t q_head;

    gsa_front #(
        .GROUPS (GROUPS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .group_index   (group_index),
        .row_value     (row_value),
        .row_selected  (row_selected),
        .value_present (value_present),
        .clearing      (clearing),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    gsa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    gsa_back #(
        .GROUPS (GROUPS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .group_out        (group_out),
        .applied          (applied),
        .group_sum        (group_sum),
        .null_groups_left (null_groups_left)
    );

endmodule

// ----- test/grouped_sum_accumulator_test.sv -----
// grouped_sum_accumulator_test: self-checking bench for the group-by sum update engine.
// Predicts every result beat from its own copy of the group sums and null flags.
// Depends on gsa_pkg and grouped_sum_accumulator.
`timescale 1ns / 1ps

module grouped_sum_accumulator_test;
    import gsa_pkg::*;

    localparam int NUM_GROUPS  = GROUPS_DEFAULT;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        logic [GROUP_W-1:0]        group;
        logic                      applied;
        logic signed [VALUE_W-1:0] sum;
        logic [COUNT_W-1:0]        nulls_left;
    } row_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [GROUP_W-1:0]        group_index;
    logic signed [VALUE_W-1:0] row_value;
    logic                      row_selected;
    logic                      value_present;
    logic                      out_valid;
    logic                      out_stall;
    logic [GROUP_W-1:0]        group_out;
    logic                      applied;
    logic signed [VALUE_W-1:0] group_sum;
    logic [COUNT_W-1:0]        null_groups_left;

    logic signed [VALUE_W-1:0] sum_table [NUM_GROUPS];
    logic                      null_flag [NUM_GROUPS];
    int                        nulls_left;
    row_result_t               pending_results [$];

    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           mismatch_count;
    int           rows_sent;
    int           rows_applied;
    int           results_seen;
    logic [GROUP_W-1:0] hot_base;

    grouped_sum_accumulator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .group_index      (group_index),
        .row_value        (row_value),
        .row_selected     (row_selected),
        .value_present    (value_present),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .group_out        (group_out),
        .applied          (applied),
        .group_sum        (group_sum),
        .null_groups_left (null_groups_left)
    );

    always #2 clk = ~clk;

    function automatic row_result_t update_group_sum(
        input logic [GROUP_W-1:0]        grp,
        input logic signed [VALUE_W-1:0] val,
        input logic                      sel,
        input logic                      pres
    );
        row_result_t r;
        logic        in_range;
        in_range  = int'(grp) < NUM_GROUPS;
        r.group   = grp;
        r.applied = sel && pres && in_range;
        r.sum     = '0;
        if (in_range)
        begin
            if (r.applied)
            begin
                if (null_flag[grp])
                begin
                    null_flag[grp] = 1'b0;
                    if (nulls_left > 0)
                        nulls_left = nulls_left - 1;
                end
                sum_table[grp] = sum_table[grp] + val;
            end
            r.sum = sum_table[grp];
        end
        r.nulls_left = COUNT_W'(nulls_left);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
        mismatch_count++;
    endtask

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, with in_valid still high.
    task automatic send_row(input logic [GROUP_W-1:0] grp, input logic signed [VALUE_W-1:0] val,
                            input logic sel, input logic pres);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        group_index   <= grp;
        row_value     <= val;
        row_selected  <= sel;
        value_present <= pres;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(update_group_sum(grp, val, sel, pres));
        rows_sent++;
        if (sel && pres)
            rows_applied++;
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(9);
        case (kind)
            0:       pick_value = {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
            1:       pick_value = {1'b1, 63'b0} + 64'($urandom_range(3));
            2, 3:    pick_value = 64'($urandom_range(200)) - 64'd100;
            default: pick_value = {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [GROUP_W-1:0] pick_group();
        if ($urandom_range(1) == 0)
            pick_group = hot_base + GROUP_W'($urandom_range(7));
        else
            pick_group = GROUP_W'($urandom_range(NUM_GROUPS - 1));
    endfunction

    task automatic send_random_row();
        logic sel;
        logic pres;
        if ($urandom_range(9) < 7)
        begin
            sel  = 1'b1;
            pres = 1'b1;
        end
        else
        begin
            sel  = 1'($urandom_range(1));
            pres = 1'($urandom_range(1));
        end
        send_row(pick_group(), pick_value(), sel, pres);
    endtask

    // Extremes of the fields, every flag combination, wrap in both directions,
    // repeated rows on one group and a read of a group still null.
    task automatic test_directed_edges();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_row(10'd0, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        send_row(10'd0, 64'sd1, 1'b1, 1'b1);
        send_row(10'd0, 64'sh8000_0000_0000_0000, 1'b1, 1'b0);
        send_row(10'd0, 64'sd5, 1'b0, 1'b1);
        send_row(10'd0, 64'sd5, 1'b0, 1'b0);
        send_row(10'd1023, 64'sh8000_0000_0000_0000, 1'b1, 1'b1);
        send_row(10'd1023, -64'sd1, 1'b1, 1'b1);
        send_row(10'd1023, -64'sd1, 1'b0, 1'b1);
        send_row(10'd512, 64'sd77, 1'b1, 1'b0);
        send_row(10'd512, 64'sd77, 1'b0, 1'b0);
        send_row(10'h155, 64'sh5555_5555_5555_5555, 1'b1, 1'b1);
        send_row(10'h2AA, 64'shAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1);
        send_row(10'd7, 64'sd5, 1'b1, 1'b1);
        send_row(10'd7, -64'sd3, 1'b1, 1'b1);
        send_row(10'd7, 64'sd10, 1'b1, 1'b1);
        send_row(10'd7, 64'sd99, 1'b0, 1'b1);
        send_row(10'd7, -64'sd12, 1'b1, 1'b1);
        send_row(10'd8, 64'sd0, 1'b1, 1'b1);
        send_row(10'd8, 64'sd0, 1'b1, 1'b1);
        send_row(10'd1023, 64'sh7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
        wait_for_drain();
    endtask

    task automatic test_random_stream(input int rows, input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        hot_base       = GROUP_W'($urandom_range(NUM_GROUPS - 1));
        repeat (rows)
            send_random_row();
        wait_for_drain();
    endtask

    task automatic test_backpressure_fill();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 250;
        repeat (12)
            send_random_row();
        wait_for_drain();
    endtask

    // sender pauses mid-stream until every outstanding beat has come back
    task automatic test_sender_pause();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        repeat (10)
            send_random_row();
        wait_for_drain();
        repeat (10)
            send_random_row();
        wait_for_drain();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        row_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", 64'(group_out), 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (group_out !== want.group)
                    report_mismatch("group_out", 64'(group_out), 64'(want.group));
                if (applied !== want.applied)
                    report_mismatch("applied", 64'(applied), 64'(want.applied));
                if (group_sum !== want.sum)
                    report_mismatch("group_sum", group_sum, want.sum);
                if (null_groups_left !== want.nulls_left)
                    report_mismatch("null_groups_left", 64'(null_groups_left),
                                    64'(want.nulls_left));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        group_index    = '0;
        row_value      = '0;
        row_selected   = 1'b0;
        value_present  = 1'b0;
        out_stall      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        mismatch_count = 0;
        rows_sent      = 0;
        rows_applied   = 0;
        results_seen   = 0;
        hot_base       = '0;
        nulls_left     = NUM_GROUPS;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            sum_table[g] = '0;
            null_flag[g] = 1'b1;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_edges();
        test_random_stream(215, 0, 0);
        test_random_stream(215, 84, 0);
        test_backpressure_fill();
        test_random_stream(215, 0, 84);
        test_sender_pause();
        test_random_stream(195, 37, 37);

        repeat (20) @(posedge clk);
        $display("Sent %0d rows (%0d applied), checked %0d result beats.",
                 rows_sent, rows_applied, results_seen);
        $display("Groups still null at the end: %0d; mismatches: %0d.",
                 nulls_left, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
